// ===== rtl/mss_pkg.sv =====
// Shared types, codes and reset constants for the magnetometer sample sequencer.
`default_nettype none

package mss_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int NOW_W    = 32;
  localparam int RX_W     = 48;
  localparam int RAW_W    = 16;
  localparam int FIELD_W  = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 112;

  localparam logic [15:0] READY_TIMEOUT_RST   = 16'd20;
  localparam logic [15:0] OFFLINE_TIMEOUT_RST = 16'd50;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READY_TO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_TO  = 3'd5;

  typedef enum logic [FUNC_W-1:0] {
    FN_START  = 3'd0,
    FN_WDONE  = 3'd1,
    FN_DRDY   = 3'd2,
    FN_RDONE  = 3'd3,
    FN_BERR   = 3'd4,
    FN_UPDATE = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_NOT_EN  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_WAIT = 5'b00100,
    PH_READ = 5'b01000,
    PH_ERR  = 5'b10000
  } phase_t;

  localparam logic [2:0] PC_IDLE = 3'd0;
  localparam logic [2:0] PC_TRIG = 3'd1;
  localparam logic [2:0] PC_WAIT = 3'd2;
  localparam logic [2:0] PC_READ = 3'd3;
  localparam logic [2:0] PC_ERR  = 3'd4;

  typedef struct packed {
    logic                      enabled;
    logic signed [RAW_W-1:0]   offset_x;
    logic signed [RAW_W-1:0]   offset_y;
    logic signed [RAW_W-1:0]   offset_z;
    logic [15:0]               ready_to;
    logic [15:0]               offline_to;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [NOW_W-1:0]  now_ms;
    logic [RX_W-1:0]   rx_bytes;
  } item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_z;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [RAW_W-1:0]   raw_z;
    logic signed [RAW_W-1:0]   raw_y;
    logic signed [RAW_W-1:0]   raw_x;
    logic                      online;
    logic                      pending;
    logic [2:0]                phase;
    logic                      issue_read;
    logic                      issue_trigger;
    logic [1:0]                status;
  } res_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE: code = PC_IDLE;
      PH_TRIG: code = PC_TRIG;
      PH_WAIT: code = PC_WAIT;
      PH_READ: code = PC_READ;
      PH_ERR:  code = PC_ERR;
      default: code = PC_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/magnetometer_sample_sequencer.sv =====
// Top level of the magnetometer sample sequencer.
//
//   Channel  Direction  Handshake                Payload
//   s_axis   in         tvalid/tready            tdata: now_ms, rx_bytes; tuser: func
//   m_axis   out        tvalid/tready            tdata: status .. field_z
//   cfg      in         cfg_wen (no wait)        cfg_index, cfg_data
//
// Each event is held in the input register, and the state update feeds
// the result register directly, so an accepted transaction passes through the input
// register and then the result register; one event per cycle is sustained while the
// sink takes results. Reset is synchronous and clears control state and the sequencer
// state. A stalled output holds its result; the input register keeps taking a new
// transaction in the same cycle that the output register is emptied.
`default_nettype none

module magnetometer_sample_sequencer #(
  parameter int TIME_BITS = mss_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: now_ms[31:0], rx_bytes[79:32].
  input  wire logic [mss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: func[2:0], bits above ignored.
  input  wire logic [mss_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Fields from bit 0: status[1:0], issue_trigger[2], issue_read[3], phase[6:4],
  // pending[7], online[8], raw_x[24:9], raw_y[40:25], raw_z[56:41],
  // field_x[74:57], field_y[92:75], field_z[110:93], zero fill [111].
  output logic [mss_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  mss_pkg::cfg_t   cfg;
  mss_pkg::item_t  item_in;
  mss_pkg::item_t  item;
  mss_pkg::res_t   res_next;
  mss_pkg::res_t   res;
  logic            in_valid;
  logic            out_free;
  logic            adv;
  logic            in_load;

  assign item_in.func     = s_axis_tuser[mss_pkg::FUNC_W-1:0];
  assign item_in.now_ms   = s_axis_tdata[mss_pkg::NOW_W-1:0];
  assign item_in.rx_bytes = s_axis_tdata[mss_pkg::NOW_W +: mss_pkg::RX_W];

  assign adv           = in_valid && out_free;
  assign s_axis_tready = !in_valid || adv;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  mss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mss_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (in_load),
    .drain   (adv),
    .item_in (item_in),
    .valid   (in_valid),
    .item    (item)
  );

  mss_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (adv),
    .item     (item),
    .cfg      (cfg),
    .res_next (res_next)
  );

  mss_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (adv),
    .res_in (res_next),
    .take   (m_axis_tready),
    .valid  (m_axis_tvalid),
    .free   (out_free),
    .res    (res)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule

`default_nettype wire

// ===== rtl/mss_cfg.sv =====
// Configuration register file: enable, axis offsets and the two timeouts.
`default_nettype none

module mss_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mss_pkg::CFG_DATA_W-1:0] cfg_data,
  output mss_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled    <= 1'b0;
      cfg.offset_x   <= '0;
      cfg.offset_y   <= '0;
      cfg.offset_z   <= '0;
      cfg.ready_to   <= mss_pkg::READY_TIMEOUT_RST;
      cfg.offline_to <= mss_pkg::OFFLINE_TIMEOUT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        mss_pkg::REG_ENABLED:    cfg.enabled    <= cfg_data[0];
        mss_pkg::REG_OFFSET_X:   cfg.offset_x   <= cfg_data;
        mss_pkg::REG_OFFSET_Y:   cfg.offset_y   <= cfg_data;
        mss_pkg::REG_OFFSET_Z:   cfg.offset_z   <= cfg_data;
        mss_pkg::REG_READY_TO:   cfg.ready_to   <= cfg_data;
        mss_pkg::REG_OFFLINE_TO: cfg.offline_to <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mss_in_reg.sv =====
// Input register stage holding one accepted event.
`default_nettype none

module mss_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire logic           drain,
  input  wire mss_pkg::item_t item_in,
  output logic                valid,
  output mss_pkg::item_t      item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mss_core.sv =====
// Sequencer state, event handling, sample conversion and timeout checks.
`default_nettype none

module mss_core #(
  parameter int TIME_BITS = mss_pkg::TIME_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            go,
  input  wire mss_pkg::item_t  item,
  input  wire mss_pkg::cfg_t   cfg,
  output mss_pkg::res_t        res_next
);

  localparam int RAW_W   = mss_pkg::RAW_W;
  localparam int FIELD_W = mss_pkg::FIELD_W;

  mss_pkg::phase_t             phase, phase_next;
  logic                        pending, pending_next;
  logic                        online, online_next;
  logic [TIME_BITS-1:0]        wait_start, wait_start_next;
  logic [TIME_BITS-1:0]        last_sample, last_sample_next;
  logic [mss_pkg::RX_W-1:0]    sample, sample_next;
  logic signed [RAW_W-1:0]     raw [3];
  logic signed [RAW_W-1:0]     raw_next [3];
  logic signed [FIELD_W-1:0]   field [3];
  logic signed [FIELD_W-1:0]   field_next [3];

  logic [TIME_BITS-1:0]        now_t;
  logic [TIME_BITS-1:0]        wait_age;
  logic [TIME_BITS-1:0]        sample_age;
  logic signed [RAW_W-1:0]     conv_raw [3];
  logic signed [FIELD_W-1:0]   conv_field [3];
  logic signed [RAW_W-1:0]     offs [3];
  mss_pkg::phase_t             start_phase;
  mss_pkg::status_t            status;
  logic                        trig;
  logic                        rd;

  assign now_t = item.now_ms[TIME_BITS-1:0];
  assign offs[0] = cfg.offset_x;
  assign offs[1] = cfg.offset_y;
  assign offs[2] = cfg.offset_z;

  // raw * 3 - offset always fits in 18 bits, so the sum wraps harmlessly.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      conv_raw[i]   = sample[RAW_W*i +: RAW_W];
      conv_field[i] = FIELD_W'(conv_raw[i]) + (FIELD_W'(conv_raw[i]) <<< 1)
                      - FIELD_W'(offs[i]);
    end
  end

  assign wait_age = now_t - wait_start;
  assign start_phase = (phase == mss_pkg::PH_ERR) ? mss_pkg::PH_IDLE : phase;

  always_comb begin
    phase_next       = phase;
    pending_next     = pending;
    online_next      = online;
    wait_start_next  = wait_start;
    last_sample_next = last_sample;
    sample_next      = sample;
    raw_next         = raw;
    field_next       = field;
    status           = mss_pkg::ST_OK;
    trig             = 1'b0;
    rd               = 1'b0;
    sample_age       = now_t - last_sample;

    case (mss_pkg::func_t'(item.func))
      mss_pkg::FN_START: begin
        if (!cfg.enabled) begin
          status = mss_pkg::ST_NOT_EN;
        end else if (start_phase != mss_pkg::PH_IDLE || pending) begin
          status     = mss_pkg::ST_BUSY;
          phase_next = start_phase;
        end else begin
          phase_next = mss_pkg::PH_TRIG;
          trig       = 1'b1;
        end
      end
      mss_pkg::FN_WDONE: begin
        if (phase == mss_pkg::PH_TRIG) begin
          phase_next      = mss_pkg::PH_WAIT;
          wait_start_next = now_t;
        end
      end
      mss_pkg::FN_DRDY: begin
        if (phase == mss_pkg::PH_WAIT) begin
          phase_next = mss_pkg::PH_READ;
          rd         = 1'b1;
        end
      end
      mss_pkg::FN_RDONE: begin
        if (phase == mss_pkg::PH_READ) begin
          sample_next  = item.rx_bytes;
          phase_next   = mss_pkg::PH_IDLE;
          pending_next = 1'b1;
        end
      end
      mss_pkg::FN_BERR: begin
        phase_next   = mss_pkg::PH_ERR;
        pending_next = 1'b0;
        online_next  = 1'b0;
      end
      mss_pkg::FN_UPDATE: begin
        if (pending) begin
          raw_next         = conv_raw;
          field_next       = conv_field;
          online_next      = 1'b1;
          last_sample_next = now_t;
          pending_next     = 1'b0;
          sample_age       = '0;
        end
        if (phase == mss_pkg::PH_WAIT && wait_age >= TIME_BITS'(cfg.ready_to)) begin
          phase_next  = mss_pkg::PH_ERR;
          online_next = 1'b0;
        end
        if (online_next && sample_age >= TIME_BITS'(cfg.offline_to)) begin
          online_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_next.status        = status;
    res_next.issue_trigger = trig;
    res_next.issue_read    = rd;
    res_next.phase         = mss_pkg::phase_code(phase_next);
    res_next.pending       = pending_next;
    res_next.online        = online_next;
    res_next.raw_x         = raw_next[0];
    res_next.raw_y         = raw_next[1];
    res_next.raw_z         = raw_next[2];
    res_next.field_x       = field_next[0];
    res_next.field_y       = field_next[1];
    res_next.field_z       = field_next[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mss_pkg::PH_IDLE;
      pending     <= 1'b0;
      online      <= 1'b0;
      wait_start  <= '0;
      last_sample <= '0;
      for (int i = 0; i < 3; i++) begin
        raw[i]   <= '0;
        field[i] <= '0;
      end
    end else if (go) begin
      phase       <= phase_next;
      pending     <= pending_next;
      online      <= online_next;
      wait_start  <= wait_start_next;
      last_sample <= last_sample_next;
      raw         <= raw_next;
      field       <= field_next;
    end
  end

  // The sample store is only read while pending is set, so it needs no reset.
  always_ff @(posedge clk) begin
    if (go) begin
      sample <= sample_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_berr_clears: assert property (@(posedge clk) disable iff (rst)
    go && item.func == mss_pkg::FN_BERR |=> phase == mss_pkg::PH_ERR && !pending && !online)
    else $error("bus error did not enter error phase with flags cleared");

  a_update_consumes: assert property (@(posedge clk) disable iff (rst)
    go && item.func == mss_pkg::FN_UPDATE |=> !pending)
    else $error("update left a sample pending");

  a_trigger_phase: assert property (@(posedge clk) disable iff (rst)
    go && trig |=> phase == mss_pkg::PH_TRIG)
    else $error("trigger issued without entering triggering phase");

  a_disabled_start: assert property (@(posedge clk) disable iff (rst)
    go && item.func == mss_pkg::FN_START && !cfg.enabled |=> $stable(phase) && !$past(trig))
    else $error("start while disabled changed the phase");

  a_read_only_from_wait: assert property (@(posedge clk) disable iff (rst)
    go && rd |-> phase == mss_pkg::PH_WAIT && item.func == mss_pkg::FN_DRDY)
    else $error("read issued outside the waiting phase");
`endif

endmodule

`default_nettype wire

// ===== rtl/mss_out_reg.sv =====
// Result register that holds one finished result until the sink takes it.
`default_nettype none

module mss_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire mss_pkg::res_t res_in,
  input  wire logic          take,
  output logic               valid,
  output logic               free,
  output mss_pkg::res_t      res
);

  logic valid_next;

  assign free = !valid || take;
  assign valid_next = load || (valid && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

`default_nettype wire
